// ===== hw/rtl/telnet_receive_filter_top_defines.svh =====
// Assertion macros shared by the telnet receive filter RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef TELNET_RECEIVE_FILTER_TOP_DEFINES_SVH
`define TELNET_RECEIVE_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define TRF_ASSERT_IMPL(name, clk_sig, rstn_sig, ante, cons) \
    name: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, disabled while reset is asserted
`define TRF_ASSERT_NEXT(name, clk_sig, rstn_sig, ante, cons) \
    name: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== hw/rtl/trf_pkg.sv =====
// Shared types and constants for the telnet receive filter.
// Used by trf_parser, trf_result_queue and telnet_receive_filter_top.
package trf_pkg;

    // Default counter width and result limits
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int MAX_RESULTS     = 6;
    localparam int RES_IDX_W       = $clog2(MAX_RESULTS);
    localparam int RES_CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int QUEUE_DEPTH     = 4;

    // Telnet command bytes
    localparam logic [7:0] B_IAC  = 8'd255;
    localparam logic [7:0] B_DONT = 8'd254;
    localparam logic [7:0] B_DO   = 8'd253;
    localparam logic [7:0] B_WONT = 8'd252;
    localparam logic [7:0] B_WILL = 8'd251;
    localparam logic [7:0] B_SB   = 8'd250;
    localparam logic [7:0] B_SE   = 8'd240;
    localparam logic [7:0] B_NOP  = 8'd241;

    // Configuration register indexes
    localparam logic REG_OPTION_MASK = 1'b0;
    localparam logic REG_AUTO_REPLY  = 1'b1;

    typedef enum logic [2:0] {
        KIND_DATA  = 3'd0,
        KIND_REPLY = 3'd1,
        KIND_EVENT = 3'd2,
        KIND_SUB   = 3'd3,
        KIND_CHUNK = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_READY  = 3'd0,
        ST_CMD    = 3'd1,
        ST_OPT    = 3'd2,
        ST_SBOPT  = 3'd3,
        ST_SBTYPE = 3'd4,
        ST_SBVAL  = 3'd5,
        ST_SBIAC  = 3'd6
    } parse_state_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] value;
        logic [7:0]  command_code;
        logic [7:0]  option_code;
        logic [7:0]  sub_type;
        logic [15:0] sub_count;
    } result_t;

    // All results caused by one received byte, item 0 first
    typedef struct packed {
        logic [RES_CNT_W-1:0]          count;
        result_t [MAX_RESULTS-1:0]     items;
    } bundle_t;

endpackage

// ===== hw/rtl/trf_parser.sv =====
// Input register, Telnet parse state and per-byte result bundle builder.
// Depends on trf_pkg; feeds bundles to trf_result_queue.
module trf_parser #(
    parameter int COUNT_WIDTH = trf_pkg::COUNT_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,             // [7:0] rx_byte
    input  logic             s_tlast,             // chunk_end
    input  logic [63:0]      option_support_mask,
    input  logic             auto_reply_enable,
    input  logic             queue_space,
    output logic             bundle_push,
    output trf_pkg::bundle_t bundle
);
    import trf_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CNT_CAP =
        (COUNT_WIDTH < 16) ? {COUNT_WIDTH{1'b1}} : COUNT_WIDTH'(65535);

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_end_reg;
    parse_state_t           state_reg, state_next;
    logic [7:0]             cmd_reg, cmd_next;
    logic [7:0]             opt_reg, opt_next;
    logic [7:0]             typ_reg, typ_next;
    logic [COUNT_WIDTH-1:0] pay_reg, pay_next;
    logic [COUNT_WIDTH-1:0] kept_reg, kept_next;
    logic                   proc;
    logic                   do_cmd;
    logic                   supported;
    logic [7:0]             reply_code;
    logic [RES_CNT_W-1:0]   n;
    bundle_t                bun;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v >= CNT_CAP) ? v : v + 1'b1;
    endfunction

    function automatic result_t mk(input kind_t k, input logic [15:0] v,
                                   input logic [7:0] cm, input logic [7:0] op,
                                   input logic [7:0] ty, input logic [15:0] cn);
        result_t r;
        r.kind         = k;
        r.value        = v;
        r.command_code = cm;
        r.option_code  = op;
        r.sub_type     = ty;
        r.sub_count    = cn;
        return r;
    endfunction

    // Process the held byte whenever the queue can take its bundle
    assign proc        = in_valid_reg && queue_space;
    assign s_tready    = !in_valid_reg || queue_space;
    assign bundle_push = proc && (n != '0);
    assign bundle      = bun;
    assign supported   = (in_byte_reg[7:6] == 2'b00) && option_support_mask[in_byte_reg[5:0]];

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (proc)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
    end

    // Parse state and held fields
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_READY;
            cmd_reg   <= B_NOP;
            opt_reg   <= '0;
            typ_reg   <= '0;
            pay_reg   <= '0;
            kept_reg  <= '0;
        end
        else if (proc)
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
            opt_reg   <= opt_next;
            typ_reg   <= typ_next;
            pay_reg   <= pay_next;
            kept_reg  <= kept_next;
        end
    end

    // Next state and result bundle for the held byte
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        opt_next   = opt_reg;
        typ_next   = typ_reg;
        pay_next   = pay_reg;
        kept_next  = kept_reg;
        do_cmd     = 1'b0;
        reply_code = B_WONT;
        n          = '0;
        bun        = '0;

        unique case (state_reg)
            ST_READY:
            begin
                if (in_byte_reg == B_IAC)
                begin
                    state_next = ST_CMD;
                end
                else
                begin
                    bun.items[n[RES_IDX_W-1:0]] = mk(KIND_DATA, 16'(in_byte_reg), '0, '0, '0, '0);
                    n         = n + RES_CNT_W'(1);
                    kept_next = sat_inc(kept_reg);
                end
            end
            ST_CMD:
            begin
                do_cmd = 1'b1;
            end
            ST_OPT:
            begin
                opt_next = in_byte_reg;
                bun.items[n[RES_IDX_W-1:0]] = mk(KIND_EVENT, '0, cmd_reg, in_byte_reg, '0, '0);
                n = n + RES_CNT_W'(1);
                if (auto_reply_enable)
                begin
                    if (cmd_reg == B_WILL)
                    begin
                        reply_code = supported ? B_DO : B_DONT;
                    end
                    else if (cmd_reg == B_DO)
                    begin
                        reply_code = supported ? B_WILL : B_WONT;
                    end
                    else if (cmd_reg == B_WONT)
                    begin
                        reply_code = B_DONT;
                    end
                    else
                    begin
                        reply_code = B_WONT;
                    end
                    bun.items[n[RES_IDX_W-1:0]] = mk(KIND_REPLY, 16'(B_IAC), '0, '0, '0, '0);
                    n = n + RES_CNT_W'(1);
                    bun.items[n[RES_IDX_W-1:0]] = mk(KIND_REPLY, 16'(reply_code), '0, '0, '0, '0);
                    n = n + RES_CNT_W'(1);
                    bun.items[n[RES_IDX_W-1:0]] = mk(KIND_REPLY, 16'(in_byte_reg), '0, '0, '0, '0);
                    n = n + RES_CNT_W'(1);
                end
                state_next = ST_READY;
            end
            ST_SBOPT:
            begin
                opt_next   = in_byte_reg;
                state_next = ST_SBTYPE;
            end
            ST_SBTYPE:
            begin
                typ_next   = in_byte_reg;
                state_next = ST_SBVAL;
            end
            ST_SBVAL:
            begin
                if (in_byte_reg == B_IAC)
                begin
                    state_next = ST_SBIAC;
                end
                else
                begin
                    bun.items[n[RES_IDX_W-1:0]] = mk(KIND_SUB, 16'(in_byte_reg), '0, '0, '0, '0);
                    n        = n + RES_CNT_W'(1);
                    pay_next = sat_inc(pay_reg);
                end
            end
            ST_SBIAC:
            begin
                if (in_byte_reg == B_IAC)
                begin
                    bun.items[n[RES_IDX_W-1:0]] = mk(KIND_SUB, 16'(B_IAC), '0, '0, '0, '0);
                    n          = n + RES_CNT_W'(1);
                    pay_next   = sat_inc(pay_reg);
                    state_next = ST_SBVAL;
                end
                else
                begin
                    bun.items[n[RES_IDX_W-1:0]] =
                        mk(KIND_EVENT, '0, B_SB, opt_reg, typ_reg, 16'(pay_reg));
                    n = n + RES_CNT_W'(1);
                    if (in_byte_reg == B_SE)
                    begin
                        state_next = ST_READY;
                    end
                    else
                    begin
                        // Unterminated subnegotiation: clear and treat byte as a command
                        opt_next = '0;
                        typ_next = '0;
                        pay_next = '0;
                        do_cmd   = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_READY;
            end
        endcase

        // Byte that follows IAC outside subnegotiation payload
        if (do_cmd)
        begin
            cmd_next = in_byte_reg;
            if (in_byte_reg == B_IAC)
            begin
                bun.items[n[RES_IDX_W-1:0]] = mk(KIND_DATA, 16'(B_IAC), '0, '0, '0, '0);
                n          = n + RES_CNT_W'(1);
                kept_next  = sat_inc(kept_next);
                state_next = ST_READY;
            end
            else if (in_byte_reg == B_DO || in_byte_reg == B_DONT ||
                     in_byte_reg == B_WILL || in_byte_reg == B_WONT)
            begin
                state_next = ST_OPT;
            end
            else if (in_byte_reg == B_SB)
            begin
                pay_next   = '0;
                state_next = ST_SBOPT;
            end
            else
            begin
                bun.items[n[RES_IDX_W-1:0]] = mk(KIND_EVENT, '0, in_byte_reg, '0, '0, '0);
                n          = n + RES_CNT_W'(1);
                state_next = ST_READY;
            end
        end

        // Chunk end follows the byte's own results
        if (in_end_reg)
        begin
            bun.items[n[RES_IDX_W-1:0]] = mk(KIND_CHUNK, 16'(kept_next), '0, '0, '0, '0);
            n         = n + RES_CNT_W'(1);
            kept_next = '0;
        end

        bun.count = n;
    end

endmodule

// ===== hw/rtl/trf_result_queue.sv =====
// Bundle queue and unpacker: stores per-byte result bundles, sends one result per transaction.
// Depends on trf_pkg and telnet_receive_filter_top_defines.svh.
`include "telnet_receive_filter_top_defines.svh"

module trf_result_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  trf_pkg::bundle_t bundle,
    output logic             space,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [55:0]      m_tdata,   // value[15:0], command_code, option_code,
                                        // sub_type, sub_count[15:0]
    output logic [2:0]       m_tuser,   // kind
    output logic             m_tlast    // last
);
    import trf_pkg::*;

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    bundle_t              mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [FILL_W-1:0]    fill_reg;
    logic [RES_IDX_W-1:0] idx_reg;
    bundle_t              head;
    result_t              cur;
    logic                 pop;

    assign head     = mem_reg[rd_ptr_reg];
    assign cur      = head.items[idx_reg];
    assign space    = (fill_reg != FILL_W'(QUEUE_DEPTH));
    assign m_tvalid = (fill_reg != '0);
    assign m_tlast  = (RES_CNT_W'(idx_reg) == head.count - RES_CNT_W'(1));
    assign m_tuser  = cur.kind;
    assign m_tdata  = {cur.sub_count, cur.sub_type, cur.option_code,
                       cur.command_code, cur.value};
    assign pop      = m_tvalid && m_tready && m_tlast;

    // Bundle storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= bundle;
        end
    end

    // Pointers, fill level and position within the head bundle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
                idx_reg    <= '0;
            end
            else if (m_tvalid && m_tready)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    `TRF_ASSERT_IMPL(a_no_overflow, clk, rst_n, push, fill_reg != FILL_W'(QUEUE_DEPTH))
    `TRF_ASSERT_IMPL(a_head_count, clk, rst_n, m_tvalid,
                     (head.count != '0) && (head.count <= RES_CNT_W'(MAX_RESULTS)))
    `TRF_ASSERT_NEXT(a_idx_restart, clk, rst_n, pop, idx_reg == '0)
    `TRF_ASSERT_NEXT(a_fill_grow, clk, rst_n, push && !pop, fill_reg == $past(fill_reg) + 1'b1)

endmodule

// ===== hw/rtl/telnet_receive_filter_top.sv =====
// Top level of the telnet receive filter: configuration registers, parser and result queue.
// Depends on trf_pkg, trf_parser and trf_result_queue.
//
//  channel | direction | tdata                                       | tuser | tlast
//  s_*     | in        | rx_byte                                     | -     | chunk_end
//  m_*     | out       | value, command, option, sub_type, sub_count | kind  | last
//  cfg_*   | in        | write only: cfg_index selects, cfg_wdata    | -     | -
//
// A byte is taken every cycle while the queue has space; it is parsed while it sits in the
// input register, and its bundle of up to five results enters a four-deep bundle queue,
// from whose head its first result is then offered.
// The output side sends one result per cycle while m_tready is high; the queue absorbs
// short bursts before s_tready drops.
// Reset clears parse state, counters, queue pointers; mask resets to 0, auto reply to 1.
module telnet_receive_filter_top #(
    parameter int COUNT_WIDTH = trf_pkg::COUNT_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    input  logic        s_tlast,    // chunk_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // [15:0] value, [23:16] command_code, [31:24] option_code,
                                    // [39:32] sub_type, [55:40] sub_count
    output logic [2:0]  m_tuser,    // [2:0] kind
    output logic        m_tlast,    // last
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_wdata
);
    import trf_pkg::*;

    logic [63:0] mask_reg;
    logic        auto_reg;
    logic        queue_space;
    logic        bundle_push;
    bundle_t     bundle;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
            auto_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OPTION_MASK: mask_reg <= cfg_wdata;
                REG_AUTO_REPLY:  auto_reg <= cfg_wdata[0];
                default:         mask_reg <= mask_reg;
            endcase
        end
    end

    trf_parser #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_parser (
        .clk                 (clk),
        .rst_n               (rst_n),
        .s_tvalid            (s_tvalid),
        .s_tready            (s_tready),
        .s_tdata             (s_tdata),
        .s_tlast             (s_tlast),
        .option_support_mask (mask_reg),
        .auto_reply_enable   (auto_reg),
        .queue_space         (queue_space),
        .bundle_push         (bundle_push),
        .bundle              (bundle)
    );

    trf_result_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (bundle_push),
        .bundle   (bundle),
        .space    (queue_space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
